// ===== src/wrct_pkg.sv =====
// package for the weakest-replace contributor table
// holds sizes, function codes and the scan and write transaction types
// used by wrct_cell, wrct_ctrl and weakest_replace_contributor_table_top
package wrct_pkg;

    // table size and field widths
    localparam int SLOTS      = 6;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ID_W       = 16;
    localparam int INFL_W     = 16;
    localparam int FUNC_W     = 2;
    localparam int MASK_OUT_W = 6;
    localparam int SLOT_OUT_W = 3;

    // reset value of the influence threshold (Q8.8)
    localparam logic [INFL_W-1:0] MIN_INFL_RESET = INFL_W'(1);

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLR_ACT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLR_CHG = 2'd3;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [SLOTS-1:0]  mask_t;
    typedef logic [ID_W-1:0]   id_t;
    typedef logic [INFL_W-1:0] infl_t;

    // search transaction handed from cell to cell
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        id_t               src;
        infl_t             infl;
        logic              match_hit;
        slot_idx_t         match_idx;
        infl_t             match_infl;
        logic              free_hit;
        slot_idx_t         free_idx;
        logic              weak_hit;
        slot_idx_t         weak_idx;
        infl_t             weak_infl;
        id_t               weak_src;
    } scan_pkt_t;

    // entry update broadcast to the cells
    typedef struct packed {
        logic      en;
        slot_idx_t idx;
        logic      valid;
        id_t       src;
        infl_t     infl;
    } wr_cmd_t;

endpackage

// ===== src/wrct_cell.sv =====
// one table slot of the contributor chain
// holds valid, source id and influence; folds itself into the passing search
// depends on wrct_pkg
module wrct_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  wrct_pkg::slot_idx_t my_idx,
    input  logic                live_in,
    input  wrct_pkg::scan_pkt_t pkt_in,
    input  wrct_pkg::wr_cmd_t   wr,
    output logic                live_out,
    output wrct_pkg::scan_pkt_t pkt_out
);

    logic                valid_reg;
    wrct_pkg::id_t       src_reg;
    wrct_pkg::infl_t     infl_reg;
    logic                live_reg;
    wrct_pkg::scan_pkt_t pkt_reg;
    wrct_pkg::scan_pkt_t pkt_next;
    logic                hit;
    logic                wr_here;

    assign hit     = valid_reg && (src_reg == pkt_in.src);
    assign wr_here = wr.en && (wr.idx == my_idx);

    // fold this slot into the search
    always_comb
    begin
        pkt_next = pkt_in;
        if (!pkt_in.match_hit && hit)
        begin
            pkt_next.match_hit  = 1'b1;
            pkt_next.match_idx  = my_idx;
            pkt_next.match_infl = infl_reg;
        end
        if (!pkt_in.free_hit && !valid_reg)
        begin
            pkt_next.free_hit = 1'b1;
            pkt_next.free_idx = my_idx;
        end
        // strict compare keeps ties on the lowest slot
        if (!pkt_in.weak_hit || (infl_reg < pkt_in.weak_infl))
        begin
            pkt_next.weak_hit  = 1'b1;
            pkt_next.weak_idx  = my_idx;
            pkt_next.weak_infl = infl_reg;
            pkt_next.weak_src  = src_reg;
        end
    end

    // slot valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_here)
        begin
            valid_reg <= wr.valid;
        end
    end

    // slot payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg  <= '0;
            infl_reg <= '0;
        end
        else if (wr_here)
        begin
            src_reg  <= wr.src;
            infl_reg <= wr.infl;
        end
    end

    // search stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_in;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg <= pkt_next;
    end

    assign live_out = live_reg;
    assign pkt_out  = pkt_reg;

endmodule

// ===== src/wrct_ctrl.sv =====
// control of the contributor table
// launches searches, decides the slot, keeps the masks and the threshold
// depends on wrct_pkg
module wrct_ctrl
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [wrct_pkg::FUNC_W-1:0]            func,
    input  wrct_pkg::id_t                          source_id,
    input  wrct_pkg::infl_t                        influence,
    output logic                                   busy,
    input  logic                                   cfg_we,
    input  wrct_pkg::infl_t                        cfg_wdata,
    output logic                                   launch,
    output wrct_pkg::scan_pkt_t                    launch_pkt,
    input  logic                                   scan_done,
    input  wrct_pkg::scan_pkt_t                    scan_pkt,
    output wrct_pkg::wr_cmd_t                      wr,
    output logic                                   done,
    output logic                                   accepted,
    output logic [wrct_pkg::SLOT_OUT_W-1:0]        slot_index,
    output logic                                   evicted,
    output wrct_pkg::id_t                          evicted_id,
    output logic [wrct_pkg::MASK_OUT_W-1:0]        active_bits,
    output logic [wrct_pkg::MASK_OUT_W-1:0]        changed_bits
);

    localparam int EXT_W = wrct_pkg::SLOT_W + wrct_pkg::SLOT_OUT_W;

    logic                busy_reg;
    logic                done_reg;
    wrct_pkg::infl_t     min_infl_reg;
    wrct_pkg::mask_t     active_reg;
    wrct_pkg::mask_t     active_next;
    wrct_pkg::mask_t     changed_reg;
    wrct_pkg::mask_t     changed_next;
    wrct_pkg::wr_cmd_t   wr_reg;
    wrct_pkg::wr_cmd_t   wr_next;
    logic                acc_reg;
    logic                acc_next;
    wrct_pkg::slot_idx_t slot_reg;
    wrct_pkg::slot_idx_t slot_next;
    logic                ev_reg;
    logic                ev_next;
    wrct_pkg::id_t       ev_id_reg;
    wrct_pkg::id_t       ev_id_next;
    wrct_pkg::mask_t     slot_bit;
    logic [EXT_W-1:0]    slot_ext;

    // new transaction enters the chain
    assign launch = start && !busy_reg;

    always_comb
    begin
        launch_pkt        = '0;
        launch_pkt.func   = func;
        launch_pkt.src    = source_id;
        launch_pkt.infl   = influence;
    end

    // decision when the search leaves the last cell
    always_comb
    begin
        active_next  = active_reg;
        changed_next = changed_reg;
        wr_next      = '0;
        acc_next     = 1'b0;
        slot_next    = '0;
        ev_next      = 1'b0;
        ev_id_next   = '0;
        slot_bit     = '0;
        unique case (scan_pkt.func)
            wrct_pkg::FUNC_ADD:
            begin
                if (scan_pkt.infl >= min_infl_reg)
                begin
                    if (scan_pkt.match_hit)
                    begin
                        acc_next = 1'b1;
                        slot_next = scan_pkt.match_idx;
                    end
                    else if (scan_pkt.free_hit)
                    begin
                        acc_next = 1'b1;
                        slot_next = scan_pkt.free_idx;
                    end
                    else if (scan_pkt.infl > scan_pkt.weak_infl)
                    begin
                        acc_next   = 1'b1;
                        slot_next  = scan_pkt.weak_idx;
                        ev_next    = 1'b1;
                        ev_id_next = scan_pkt.weak_src;
                    end
                end
                if (acc_next)
                begin
                    slot_bit    = wrct_pkg::mask_t'(1) << slot_next;
                    active_next = active_reg | slot_bit;
                    // a returning source with equal influence is no change
                    if (!(scan_pkt.match_hit && (scan_pkt.match_infl == scan_pkt.infl)))
                    begin
                        changed_next = changed_reg | slot_bit;
                    end
                    wr_next.en    = 1'b1;
                    wr_next.idx   = slot_next;
                    wr_next.valid = 1'b1;
                    wr_next.src   = scan_pkt.src;
                    wr_next.infl  = scan_pkt.infl;
                end
            end
            wrct_pkg::FUNC_CLR_ACT:
            begin
                active_next = '0;
            end
            wrct_pkg::FUNC_DELETE:
            begin
                if (scan_pkt.match_hit)
                begin
                    acc_next      = 1'b1;
                    slot_next     = scan_pkt.match_idx;
                    slot_bit      = wrct_pkg::mask_t'(1) << slot_next;
                    active_next   = active_reg & ~slot_bit;
                    changed_next  = changed_reg | slot_bit;
                    wr_next.en    = 1'b1;
                    wr_next.idx   = slot_next;
                    wr_next.valid = 1'b0;
                    wr_next.src   = scan_pkt.src;
                    wr_next.infl  = scan_pkt.match_infl;
                end
            end
            wrct_pkg::FUNC_CLR_CHG:
            begin
                changed_next = '0;
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            min_infl_reg <= wrct_pkg::MIN_INFL_RESET;
            active_reg   <= '0;
            changed_reg  <= '0;
            wr_reg       <= '0;
        end
        else
        begin
            done_reg <= scan_done;
            wr_reg   <= scan_done ? wr_next : '0;
            if (launch)
            begin
                busy_reg <= 1'b1;
            end
            else if (done_reg)
            begin
                // release only once the slot write has landed
                busy_reg <= 1'b0;
            end
            if (scan_done)
            begin
                active_reg  <= active_next;
                changed_reg <= changed_next;
            end
            if (cfg_we)
            begin
                min_infl_reg <= cfg_wdata;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (scan_done)
        begin
            acc_reg   <= acc_next;
            slot_reg  <= slot_next;
            ev_reg    <= ev_next;
            ev_id_reg <= ev_id_next;
        end
    end

    assign busy       = busy_reg;
    assign wr         = wr_reg;
    assign done       = done_reg;
    assign accepted   = acc_reg;
    assign slot_ext   = {{wrct_pkg::SLOT_OUT_W{1'b0}}, slot_reg};
    assign slot_index = slot_ext[wrct_pkg::SLOT_OUT_W-1:0];
    assign evicted    = ev_reg;
    assign evicted_id = ev_id_reg;

    // low mask bits on the result ports
    for (genvar b = 0; b < wrct_pkg::MASK_OUT_W; b++)
    begin : g_mask_out
        if (b < wrct_pkg::SLOTS)
        begin : g_bit
            assign active_bits[b]  = active_reg[b];
            assign changed_bits[b] = changed_reg[b];
        end
        else
        begin : g_zero
            assign active_bits[b]  = 1'b0;
            assign changed_bits[b] = 1'b0;
        end
    end

endmodule

// ===== src/weakest_replace_contributor_table_top.sv =====
// top level of the weakest-replace contributor table
// a chain of wrct_cell slots searched by a transaction that steps one cell a cycle
// depends on wrct_pkg, wrct_cell, wrct_ctrl
//
//  channel   handshake              payload
//  input     start & !busy          func, source_id, influence
//  result    done (one cycle)       accepted, slot_index, evicted, evicted_id,
//                                   active_bits, changed_bits
//  config    min_influence_we       min_influence_wdata
//
// every transaction passes the cells in slot order and then the decision, which
// registers the result and the slot write and raises the done strobe.
// the table entry is updated at the end of the done cycle and busy drops with it,
// so a new transaction is taken at the earliest in the cycle after the done strobe.
// rst_n is asynchronous and clears the table, masks and threshold (to 1).
// the receiver cannot stall: done is high for exactly one cycle per result.
module weakest_replace_contributor_table_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [wrct_pkg::FUNC_W-1:0]         func,
    input  logic [wrct_pkg::ID_W-1:0]           source_id,
    input  logic [wrct_pkg::INFL_W-1:0]         influence,
    input  logic                                min_influence_we,
    input  logic [wrct_pkg::INFL_W-1:0]         min_influence_wdata,
    output logic                                done,
    output logic                                accepted,
    output logic [wrct_pkg::SLOT_OUT_W-1:0]     slot_index,
    output logic                                evicted,
    output logic [wrct_pkg::ID_W-1:0]           evicted_id,
    output logic [wrct_pkg::MASK_OUT_W-1:0]     active_bits,
    output logic [wrct_pkg::MASK_OUT_W-1:0]     changed_bits
);

    logic                live [wrct_pkg::SLOTS+1];
    wrct_pkg::scan_pkt_t pkt  [wrct_pkg::SLOTS+1];
    wrct_pkg::wr_cmd_t   wr;

    // control and decision
    wrct_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .func         (func),
        .source_id    (source_id),
        .influence    (influence),
        .busy         (busy),
        .cfg_we       (min_influence_we),
        .cfg_wdata    (min_influence_wdata),
        .launch       (live[0]),
        .launch_pkt   (pkt[0]),
        .scan_done    (live[wrct_pkg::SLOTS]),
        .scan_pkt     (pkt[wrct_pkg::SLOTS]),
        .wr           (wr),
        .done         (done),
        .accepted     (accepted),
        .slot_index   (slot_index),
        .evicted      (evicted),
        .evicted_id   (evicted_id),
        .active_bits  (active_bits),
        .changed_bits (changed_bits)
    );

    // chain of slot cells
    for (genvar i = 0; i < wrct_pkg::SLOTS; i++)
    begin : g_cell
        wrct_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_idx   (wrct_pkg::slot_idx_t'(i)),
            .live_in  (live[i]),
            .pkt_in   (pkt[i]),
            .wr       (wr),
            .live_out (live[i+1]),
            .pkt_out  (pkt[i+1])
        );
    end

endmodule
